// ----- rtl/dpq_pkg.sv -----
// Shared types and constants for the sorted-list priority queue.
`default_nettype none
package dpq_pkg;
	localparam int DEPTH = 16;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_PUSH   = 3'd1;
	localparam logic [2:0] ACT_PRIO   = 3'd2;
	localparam logic [2:0] ACT_TAKE   = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         action;
		logic [15:0]        entry_tag;
		logic signed [15:0] entry_priority;
		logic [3:0]         entry_type;
	} req_t;

	typedef struct packed {
		logic               entry_returned;
		logic [15:0]        out_tag;
		logic signed [15:0] out_priority;
		logic [3:0]         out_type;
		logic [1:0]         result_status;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [15:0] prio;
		logic [3:0]         typ;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);
endpackage
`default_nettype wire

// ----- rtl/dpq_ram.sv -----
// Simple dual-port RAM with a registered read port.
`default_nettype none
module dpq_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/deque_priority_list_queue.sv -----
// Top level: sequencer that keeps a sorted list in one RAM.
// An append goes from accept to a put state and then to the finish state, which posts the
// response once the slot is free; the next item is taken back in idle. A scan visits each
// entry with a read and a compare state, and opening or closing a gap moves each entry
// with a read and a write-back state. One item is in work at a time.
// The pace is set by the single registered RAM read port, read then written back.
// Reset clears the count and control state; the RAM needs no clearing pass.
`default_nettype none
module deque_priority_list_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire dpq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output dpq_pkg::rsp_t      rsp
);
	import dpq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRD  = 9'b000000010,
		S_SCMP = 9'b000000100,
		S_GRD  = 9'b000001000,
		S_GWR  = 9'b000010000,
		S_PUT  = 9'b000100000,
		S_CRD  = 9'b001000000,
		S_CWR  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [IW-1:0] j_q;
	logic [1:0] status_q;
	logic ret_q;
	ent_t ret_ent_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic we, re;
	logic [IW-1:0] waddr, raddr;
	ent_t wdata, rdata;

	dpq_ram #(.W(ENT_W), .D(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	logic full, empty, last;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign last = ({1'b0, j_q} == CW'(count_q - 1'b1));

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		re = (state_q == S_SRD) || (state_q == S_GRD) || (state_q == S_CRD);
		raddr = j_q;
		we = 1'b0;
		waddr = j_q;
		wdata = rdata;
		unique case (state_q)
			S_GWR: begin
				we = 1'b1;
				waddr = IW'(j_q + 1'b1);
			end
			S_CWR: begin
				we = 1'b1;
				waddr = IW'(j_q - 1'b1);
			end
			S_PUT: begin
				we = 1'b1;
				waddr = pos_q[IW-1:0];
				wdata = '{tag: req_q.entry_tag, prio: req_q.entry_priority,
					typ: req_q.entry_type};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the finish state the new response takes the slot itself.
			if (rsp_valid_q && rsp_ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						ret_q <= 1'b0;
						ret_ent_q <= '0;
						status_q <= ST_OK;
						j_q <= '0;
						pos_q <= '0;
						state_q <= S_FIN;
						unique case (req.action)
							ACT_APPEND: begin
								if (full) status_q <= ST_FULL;
								else begin
									pos_q <= count_q;
									state_q <= S_PUT;
								end
							end
							ACT_PUSH: begin
								if (full) status_q <= ST_FULL;
								else if (empty) state_q <= S_PUT;
								else begin
									j_q <= IW'(count_q - 1'b1);
									state_q <= S_GRD;
								end
							end
							ACT_PRIO: begin
								if (full) status_q <= ST_FULL;
								else if (empty) state_q <= S_PUT;
								else state_q <= S_SRD;
							end
							ACT_TAKE, ACT_REMOVE: begin
								if (empty) status_q <= ST_EMPTY;
								else state_q <= S_SRD;
							end
							default: ;
						endcase
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (req_q.action == ACT_PRIO) begin
						if (rdata.prio > req_q.entry_priority) begin
							pos_q <= {1'b0, j_q};
							j_q <= IW'(count_q - 1'b1);
							state_q <= S_GRD;
						end else if (last) begin
							pos_q <= count_q;
							state_q <= S_PUT;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_SRD;
						end
					end else if (req_q.action == ACT_TAKE ||
						rdata.tag == req_q.entry_tag) begin
						ret_q <= 1'b1;
						ret_ent_q <= rdata;
						if (last) begin
							count_q <= count_q - 1'b1;
							state_q <= S_FIN;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_CRD;
						end
					end else if (last) begin
						status_q <= ST_NOTFOUND;
						state_q <= S_FIN;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_GRD: state_q <= S_GWR;
				S_GWR: begin
					if ({1'b0, j_q} == pos_q) state_q <= S_PUT;
					else begin
						j_q <= j_q - 1'b1;
						state_q <= S_GRD;
					end
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (last) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_q <= '{entry_returned: ret_q, out_tag: ret_ent_q.tag,
							out_priority: ret_ent_q.prio, out_type: ret_ent_q.typ,
							result_status: status_q, occupancy: 5'(count_q)};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("entry count beyond depth");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("second item taken");
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response outside finish");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == CW'($past(count_q) + 1'b1) ||
		count_q == CW'($past(count_q) - 1'b1)) else $error("count jumped");
`endif
endmodule
`default_nettype wire

// ----- dv/deque_priority_list_queue_tb.sv -----
// Self-checking testbench for the sorted-list priority queue.
`timescale 1ns / 100ps
`default_nettype none
module deque_priority_list_queue_tb;
	import dpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	deque_priority_list_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #1 clk = ~clk;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	ent_t list_model[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int accepted = 0;
	int checked = 0;
	bit stim_done = 1'b0;

	// Applies one request to the shadow list and returns the response it should give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		ent_t e;
		int pos;
		o = '0;
		e.tag = r.entry_tag;
		e.prio = r.entry_priority;
		e.typ = r.entry_type;
		pos = 0;
		case (r.action)
			ACT_APPEND, ACT_PUSH, ACT_PRIO: begin
				if (list_model.size() >= DEPTH) begin
					o.result_status = ST_FULL;
				end else begin
					if (r.action == ACT_APPEND) begin
						pos = list_model.size();
					end else if (r.action == ACT_PRIO) begin
						while (pos < list_model.size() && list_model[pos].prio <= e.prio)
							pos++;
					end
					list_model.insert(pos, e);
				end
			end
			ACT_TAKE, ACT_REMOVE: begin
				if (list_model.size() == 0) begin
					o.result_status = ST_EMPTY;
				end else begin
					if (r.action == ACT_REMOVE) begin
						while (pos < list_model.size() && list_model[pos].tag != r.entry_tag)
							pos++;
					end
					if (pos < list_model.size()) begin
						o.entry_returned = 1'b1;
						o.out_tag = list_model[pos].tag;
						o.out_priority = list_model[pos].prio;
						o.out_type = list_model[pos].typ;
						list_model.delete(pos);
					end else begin
						o.result_status = ST_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
		o.occupancy = 5'(list_model.size());
		return o;
	endfunction

	// Driver: raises valid only from a low state or right after an accept.
	always @(posedge clk) begin
		if (req_valid && req_ready) begin
			expected_rsps.push_back(apply_request(req));
			accepted <= accepted + 1;
		end
		if (!req_valid || req_ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Monitor.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: response with none expected, actual %p", $time, rsp);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				checked++;
				if (rsp !== want) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, rsp);
					errors++;
				end
			end
		end
	end

	function automatic req_t make_req(logic [2:0] a, logic [15:0] t, logic [15:0] p,
		logic [3:0] y);
		req_t r;
		r.action = a;
		r.entry_tag = t;
		r.entry_priority = p;
		r.entry_type = y;
		return r;
	endfunction

	// Random request; tags come from a small pool so removes often hit.
	function automatic req_t random_req();
		int sel;
		logic [2:0] a;
		logic [15:0] t;
		sel = $urandom_range(99);
		if (sel < 20) a = ACT_APPEND;
		else if (sel < 35) a = ACT_PUSH;
		else if (sel < 60) a = ACT_PRIO;
		else if (sel < 78) a = ACT_TAKE;
		else if (sel < 97) a = ACT_REMOVE;
		else a = 3'($urandom_range(7, 5));
		t = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
		return make_req(a, t,
			($urandom_range(1) == 0) ? 16'($urandom) : 16'($signed($urandom_range(6)) - 3),
			4'($urandom));
	endfunction

	task automatic run_phase(int idle, int stall, int count);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			pending_reqs.push_back(random_req());
		wait (pending_reqs.size() == 0 && !req_valid);
		wait (accepted == checked && expected_rsps.size() == 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: empty cases, field extremes, fill to full, ordering, misses.
		pending_reqs.push_back(make_req(ACT_TAKE, 16'h0, 16'h0, 4'h0));
		pending_reqs.push_back(make_req(ACT_REMOVE, 16'hFFFF, 16'h0, 4'h0));
		pending_reqs.push_back(make_req(ACT_PRIO, 16'hFFFF, 16'h7FFF, 4'hF));
		pending_reqs.push_back(make_req(ACT_PRIO, 16'h0000, 16'h8000, 4'h0));
		pending_reqs.push_back(make_req(ACT_PRIO, 16'hAAAA, 16'h0000, 4'hA));
		pending_reqs.push_back(make_req(ACT_PRIO, 16'h5555, 16'h0000, 4'h5));
		pending_reqs.push_back(make_req(ACT_PUSH, 16'h1234, 16'h7FFF, 4'h3));
		pending_reqs.push_back(make_req(ACT_APPEND, 16'h4321, 16'h8000, 4'hC));
		pending_reqs.push_back(make_req(ACT_REMOVE, 16'hBEEF, 16'h0, 4'h0));
		pending_reqs.push_back(make_req(ACT_REMOVE, 16'h5555, 16'h0, 4'h0));
		pending_reqs.push_back(make_req(3'd5, 16'h1, 16'h1, 4'h1));
		pending_reqs.push_back(make_req(3'd7, 16'hFFFF, 16'hFFFF, 4'hF));
		for (int i = 0; i < 12; i++)
			pending_reqs.push_back(make_req(ACT_APPEND, 16'(i), 16'(i), 4'(i)));
		pending_reqs.push_back(make_req(ACT_PRIO, 16'h7777, 16'h0, 4'h7));
		wait (pending_reqs.size() == 0 && !req_valid);
		wait (accepted == checked && expected_rsps.size() == 0);
		run_phase(0, 0, 190);
		run_phase(53, 0, 180);
		run_phase(0, 53, 180);
		run_phase(27, 27, 180);
		repeat (200) @(posedge clk);
		$display("Ran %0d requests of all five actions plus unused codes, with full and empty",
			accepted);
		$display("lists, under four idle and stall mixes; %0d responses checked.", checked);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("deque_priority_list_queue_tb: done, clean");
		end else begin
			$display("deque_priority_list_queue_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("deque_priority_list_queue_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
